@@ hdl/npcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared constants, types and helpers for the nearest palette color search.
// ----------------------------------------------------------------------------
package npcs_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int CHAN_W            = 6;
    localparam int BYTE_W            = 8;
    localparam int IDX_W             = 8;
    localparam int SIZE_W            = 9;
    localparam int SUM_W             = 8;
    localparam int ENTRY_W           = 3 * CHAN_W;
    localparam int INDEX_LIMIT       = 256;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic             load;
        logic             wr;
        logic             rd_en;
        logic             eval;
        logic [IDX_W-1:0] rd_idx;
        logic [IDX_W-1:0] eval_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic exact;
    } t_dp_status;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ hdl/npcs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module npcs_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/npcs_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcs_datapath
// Palette store, query color, distance evaluation and best-entry registers.
// ----------------------------------------------------------------------------
module npcs_datapath
    import npcs_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    input  logic [IDX_W-1:0]   i_entry_index,
    input  logic [BYTE_W-1:0]  i_red,
    input  logic [BYTE_W-1:0]  i_green,
    input  logic [BYTE_W-1:0]  i_blue,
    output logic [IDX_W-1:0]   o_best_index,
    output logic [CHAN_W-1:0]  o_best_max_distance,
    output logic [SUM_W-1:0]   o_best_sum_distance,
    output logic               o_palette_empty
);

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    logic [ENTRY_W-1:0] w_rd_data;
    logic               w_wr_en;
    logic [ENTRY_W-1:0] w_wr_data;

    logic [CHAN_W-1:0]  r_q_red;
    logic [CHAN_W-1:0]  r_q_green;
    logic [CHAN_W-1:0]  r_q_blue;
    logic [IDX_W-1:0]   r_best_idx;
    logic [CHAN_W-1:0]  r_best_max;
    logic [SUM_W-1:0]   r_best_sum;
    logic               r_found;

    logic [CHAN_W-1:0]  w_dr;
    logic [CHAN_W-1:0]  w_dg;
    logic [CHAN_W-1:0]  w_db;
    logic [CHAN_W-1:0]  w_mx;
    logic [SUM_W-1:0]   w_sm;
    logic               w_better;

    // drop writes beyond the store depth
    assign w_wr_en   = i_cmd.wr && (32'(i_entry_index) < 32'(PALETTE_DEPTH));
    assign w_wr_data = {i_red[CHAN_W-1:0], i_green[CHAN_W-1:0], i_blue[CHAN_W-1:0]};

    npcs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PALETTE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(i_entry_index)),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (AW'(i_cmd.rd_idx)),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        w_dr = abs_diff(r_q_red,   w_rd_data[3*CHAN_W-1:2*CHAN_W]);
        w_dg = abs_diff(r_q_green, w_rd_data[2*CHAN_W-1:CHAN_W]);
        w_db = abs_diff(r_q_blue,  w_rd_data[CHAN_W-1:0]);
        w_mx = (w_dr > w_dg) ? w_dr : w_dg;
        if (w_db > w_mx) begin
            w_mx = w_db;
        end
        w_sm = SUM_W'(w_dr) + SUM_W'(w_dg) + SUM_W'(w_db);
        w_better = !r_found || (w_mx < r_best_max) ||
                   ((w_mx == r_best_max) && (w_sm < r_best_sum));
    end

    assign o_status.exact = i_cmd.eval && (w_mx == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_found <= 1'b0;
        end else if (i_cmd.eval && w_better) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_q_red    <= i_red[CHAN_W-1:0];
            r_q_green  <= i_green[CHAN_W-1:0];
            r_q_blue   <= i_blue[CHAN_W-1:0];
            r_best_idx <= '0;
            r_best_max <= '0;
            r_best_sum <= '0;
        end else if (i_cmd.eval && w_better) begin
            r_best_idx <= i_cmd.eval_idx;
            r_best_max <= w_mx;
            r_best_sum <= w_sm;
        end
    end

    assign o_best_index        = r_best_idx;
    assign o_best_max_distance = r_best_max;
    assign o_best_sum_distance = r_best_sum;
    assign o_palette_empty     = !r_found;

endmodule

@@ hdl/npcs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcs_ctrl
// Request handshake, size register and scan sequencer for the search.
// ----------------------------------------------------------------------------
module npcs_ctrl
    import npcs_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_command,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    output t_dp_cmd           o_cmd,
    input  t_dp_status        i_status,
    output logic              o_result_valid
);

    localparam int SCAN_LIMIT = (PALETTE_DEPTH < INDEX_LIMIT) ? PALETTE_DEPTH : INDEX_LIMIT;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state             r_state, n_state;
    logic               r_busy, n_busy;
    logic               r_strobe, n_strobe;
    logic [SIZE_W-1:0]  r_size;
    logic [SIZE_W-1:0]  r_issue, n_issue;
    logic               r_eval_vld, n_eval_vld;
    logic [IDX_W-1:0]   r_eval_idx, n_eval_idx;

    logic [SIZE_W-1:0]  w_count;
    logic               w_accept;
    logic               w_rd_en;
    logic               w_last;

    assign w_count  = (r_size > SIZE_W'(SCAN_LIMIT)) ? SIZE_W'(SCAN_LIMIT) : r_size;
    assign w_accept = start && !r_busy;
    assign w_rd_en  = (r_state == ST_SCAN) && (r_issue < w_count);
    assign w_last   = ({1'b0, r_eval_idx} == (w_count - SIZE_W'(1)));

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = w_accept && (i_command == CMD_QUERY);
        o_cmd.wr       = w_accept && (i_command == CMD_WRITE);
        o_cmd.rd_en    = w_rd_en;
        o_cmd.rd_idx   = r_issue[IDX_W-1:0];
        o_cmd.eval     = (r_state == ST_SCAN) && r_eval_vld;
        o_cmd.eval_idx = r_eval_idx;
    end

    always_comb begin
        n_state    = r_state;
        n_busy     = r_busy;
        n_strobe   = 1'b0;
        n_issue    = r_issue;
        n_eval_vld = 1'b0;
        n_eval_idx = r_eval_idx;
        case (r_state)
            ST_IDLE: begin
                n_issue = '0;
                if (w_accept && (i_command == CMD_QUERY)) begin
                    n_busy = 1'b1;
                    if (w_count == '0) begin
                        n_state  = ST_DONE;
                        n_strobe = 1'b1;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (w_rd_en) begin
                    n_issue    = r_issue + SIZE_W'(1);
                    n_eval_vld = 1'b1;
                    n_eval_idx = r_issue[IDX_W-1:0];
                end
                if (r_eval_vld && (i_status.exact || w_last)) begin
                    n_state    = ST_DONE;
                    n_strobe   = 1'b1;
                    n_eval_vld = 1'b0;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
                n_busy  = 1'b0;
            end
            default: begin
                n_state = ST_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_busy     <= 1'b0;
            r_strobe   <= 1'b0;
            r_issue    <= '0;
            r_eval_vld <= 1'b0;
            r_eval_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_busy     <= n_busy;
            r_strobe   <= n_strobe;
            r_issue    <= n_issue;
            r_eval_vld <= n_eval_vld;
            r_eval_idx <= n_eval_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_wdata;
        end
    end

    assign busy           = r_busy;
    assign o_result_valid = r_strobe;

endmodule

@@ hdl/nearest_palette_color_search_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_search_top
// Palette store with nearest color search under the largest channel difference.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A palette write is
// stored at that edge and keeps busy low, so writes go one per cycle. A query
// raises busy and reads one palette entry per cycle from the store's single
// read port, until the search size is reached or an exact match ends the
// scan early; with a search size of zero the scan is skipped entirely. The
// result shows for exactly one cycle with o_result_valid, in the last busy
// cycle; the receiver cannot stall it, so take it when it shows. Write
// i_cfg_wdata only while busy is low.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_top
    import npcs_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_command,
    input  logic [IDX_W-1:0]  i_entry_index,
    input  logic [BYTE_W-1:0] i_red,
    input  logic [BYTE_W-1:0] i_green,
    input  logic [BYTE_W-1:0] i_blue,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    output logic              o_result_valid,
    output logic [IDX_W-1:0]  o_best_index,
    output logic [CHAN_W-1:0] o_best_max_distance,
    output logic [SUM_W-1:0]  o_best_sum_distance,
    output logic              o_palette_empty
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    npcs_ctrl #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_cmd          (w_cmd),
        .i_status       (w_status),
        .o_result_valid (o_result_valid)
    );

    npcs_datapath #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .i_entry_index       (i_entry_index),
        .i_red               (i_red),
        .i_green             (i_green),
        .i_blue              (i_blue),
        .o_best_index        (o_best_index),
        .o_best_max_distance (o_best_max_distance),
        .o_best_sum_distance (o_best_sum_distance),
        .o_palette_empty     (o_palette_empty)
    );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest palette color search. A directed table
// covers the empty palette, channel extremes, exact-match early stop and the
// tie breaks. Random phases then reprogram the search size, fill any entries
// the search would reach, and issue bursts of mixed writes and queries. Each
// query result is checked field by field against the table's expected result
// or an in-bench search over a shadow copy of the palette.
// ----------------------------------------------------------------------------
module tb_top;
    import npcs_pkg::*;

    localparam int TOTAL_REQUESTS = 1650;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PRINT_CAP      = 100;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [CHAN_W-1:0] max_dist;
        logic [SUM_W-1:0]  sum_dist;
        logic              empty;
    } match_t;

    typedef enum logic [1:0] {ROW_SIZE, ROW_WRITE, ROW_QUERY} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [SIZE_W-1:0] size;
        logic              typed;
        match_t            result;
    } stim_row_t;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              start          = 1'b0;
    logic              busy;
    logic              i_command      = CMD_WRITE;
    logic [IDX_W-1:0]  i_entry_index  = '0;
    logic [BYTE_W-1:0] i_red          = '0;
    logic [BYTE_W-1:0] i_green        = '0;
    logic [BYTE_W-1:0] i_blue         = '0;
    logic              i_cfg_we       = 1'b0;
    logic [SIZE_W-1:0] i_cfg_wdata    = '0;
    logic              o_result_valid;
    logic [IDX_W-1:0]  o_best_index;
    logic [CHAN_W-1:0] o_best_max_distance;
    logic [SUM_W-1:0]  o_best_sum_distance;
    logic              o_palette_empty;

    logic [ENTRY_W-1:0] palette_mem [INDEX_LIMIT];
    logic               written     [INDEX_LIMIT];
    logic [SIZE_W-1:0]  search_size = '0;
    match_t             pending_matches [$];
    int                 mismatch_count = 0;
    int                 requests_sent  = 0;
    int                 cycle_count    = 0;

    nearest_palette_color_search_top uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_command           (i_command),
        .i_entry_index       (i_entry_index),
        .i_red               (i_red),
        .i_green             (i_green),
        .i_blue              (i_blue),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .o_result_valid      (o_result_valid),
        .o_best_index        (o_best_index),
        .o_best_max_distance (o_best_max_distance),
        .o_best_sum_distance (o_best_sum_distance),
        .o_palette_empty     (o_palette_empty)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int scan_length();
        return (search_size > INDEX_LIMIT) ? INDEX_LIMIT : int'(search_size);
    endfunction

    function automatic match_t nearest_match(input logic [CHAN_W-1:0] r,
                                             input logic [CHAN_W-1:0] g,
                                             input logic [CHAN_W-1:0] b);
        match_t             best;
        logic [ENTRY_W-1:0] e;
        int                 dr, dg, db, mx, sm;
        bit                 hit;
        best = '{index: '0, max_dist: '0, sum_dist: '0, empty: 1'b1};
        hit  = 1'b0;
        for (int i = 0; i < scan_length() && !hit; i++) begin
            e  = palette_mem[IDX_W'(i)];
            dr = int'(r) - int'(e[2*CHAN_W +: CHAN_W]);
            dg = int'(g) - int'(e[CHAN_W +: CHAN_W]);
            db = int'(b) - int'(e[0 +: CHAN_W]);
            if (dr < 0) dr = -dr;
            if (dg < 0) dg = -dg;
            if (db < 0) db = -db;
            mx = (dr > dg) ? dr : dg;
            if (db > mx) mx = db;
            sm = dr + dg + db;
            if (best.empty || mx < best.max_dist ||
                (mx == best.max_dist && sm < best.sum_dist)) begin
                best.index    = i[IDX_W-1:0];
                best.max_dist = mx[CHAN_W-1:0];
                best.sum_dist = sm[SUM_W-1:0];
                best.empty    = 1'b0;
            end
            hit = (mx == 0);
        end
        return best;
    endfunction

    function automatic logic [BYTE_W-1:0] random_channel();
        if ($urandom_range(0, 1) == 0)
            return BYTE_W'($urandom_range(0, 255));
        // cluster values to provoke ties
        return {2'($urandom_range(0, 3)), 6'($urandom_range(30, 34))};
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
    endtask

    task automatic issue(input logic cmd, input logic [IDX_W-1:0] idx,
                         input logic [BYTE_W-1:0] r, input logic [BYTE_W-1:0] g,
                         input logic [BYTE_W-1:0] b, input logic typed,
                         input match_t typed_result);
        start         <= 1'b1;
        i_command     <= cmd;
        i_entry_index <= idx;
        i_red         <= r;
        i_green       <= g;
        i_blue        <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        requests_sent++;
        if (cmd == CMD_WRITE) begin
            palette_mem[idx] = {r[CHAN_W-1:0], g[CHAN_W-1:0], b[CHAN_W-1:0]};
            written[idx]     = 1'b1;
        end else begin
            pending_matches.push_back(typed ? typed_result :
                nearest_match(r[CHAN_W-1:0], g[CHAN_W-1:0], b[CHAN_W-1:0]));
        end
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (busy || pending_matches.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_size(input logic [SIZE_W-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        search_size = value;
    endtask

    always @(posedge i_clk) begin
        match_t want;
        if (i_rst_n && o_result_valid) begin
            if (pending_matches.size() == 0) begin
                report_mismatch("result with no query pending, best_index", 0,
                                int'(o_best_index));
            end else begin
                want = pending_matches.pop_front();
                if (o_best_index !== want.index)
                    report_mismatch("best_index", int'(want.index), int'(o_best_index));
                if (o_best_max_distance !== want.max_dist)
                    report_mismatch("best_max_distance", int'(want.max_dist),
                                    int'(o_best_max_distance));
                if (o_best_sum_distance !== want.sum_dist)
                    report_mismatch("best_sum_distance", int'(want.sum_dist),
                                    int'(o_best_sum_distance));
                if (o_palette_empty !== want.empty)
                    report_mismatch("palette_empty", int'(want.empty),
                                    int'(o_palette_empty));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        stim_row_t          stim_rows [23];
        logic [SIZE_W-1:0]  size_pick;
        logic [ENTRY_W-1:0] base;
        logic [BYTE_W-1:0]  r, g, b;
        int                 phase, phase_len, burst_left, scan, pick;

        for (int i = 0; i < INDEX_LIMIT; i++) written[IDX_W'(i)] = 1'b0;

        stim_rows[0]  = '{ROW_SIZE,  8'd0,   8'h00, 8'h00, 8'h00, 9'd0, 1'b0,
                          '{8'd0, 6'd0, 8'd0, 1'b0}};
        stim_rows[1]  = '{ROW_QUERY, 8'hFF,  8'h12, 8'h34, 8'h56, 9'd0, 1'b1,
                          '{8'd0, 6'd0, 8'd0, 1'b1}};
        stim_rows[2]  = '{ROW_QUERY, 8'd0,   8'hFF, 8'hFF, 8'hFF, 9'd0, 1'b1,
                          '{8'd0, 6'd0, 8'd0, 1'b1}};
        stim_rows[3]  = '{ROW_WRITE, 8'd0,   8'hFF, 8'hFF, 8'hFF, 9'd0, 1'b0,
                          '{8'd0, 6'd0, 8'd0, 1'b0}};
        stim_rows[4]  = '{ROW_WRITE, 8'd1,   8'h00, 8'h00, 8'h00, 9'd0, 1'b0,
                          '{8'd0, 6'd0, 8'd0, 1'b0}};
        stim_rows[5]  = '{ROW_WRITE, 8'd2,   8'h20, 8'h20, 8'h20, 9'd0, 1'b0,
                          '{8'd0, 6'd0, 8'd0, 1'b0}};
        stim_rows[6]  = '{ROW_WRITE, 8'd3,   8'hE0, 8'h60, 8'hA0, 9'd0, 1'b0,
                          '{8'd0, 6'd0, 8'd0, 1'b0}};
        stim_rows[7]  = '{ROW_WRITE, 8'd4,   8'h21, 8'h1F, 8'h20, 9'd0, 1'b0,
                          '{8'd0, 6'd0, 8'd0, 1'b0}};
        stim_rows[8]  = '{ROW_WRITE, 8'd5,   8'h1F, 8'h21, 8'h20, 9'd0, 1'b0,
                          '{8'd0, 6'd0, 8'd0, 1'b0}};
        stim_rows[9]  = '{ROW_WRITE, 8'd6,   8'h22, 8'h20, 8'h20, 9'd0, 1'b0,
                          '{8'd0, 6'd0, 8'd0, 1'b0}};
        stim_rows[10] = '{ROW_WRITE, 8'd255, 8'h3F, 8'hC0, 8'hBF, 9'd0, 1'b0,
                          '{8'd0, 6'd0, 8'd0, 1'b0}};
        stim_rows[11] = '{ROW_SIZE,  8'd0,   8'h00, 8'h00, 8'h00, 9'd1, 1'b0,
                          '{8'd0, 6'd0, 8'd0, 1'b0}};
        stim_rows[12] = '{ROW_QUERY, 8'd0,   8'h00, 8'h00, 8'h00, 9'd0, 1'b1,
                          '{8'd0, 6'd63, 8'd189, 1'b0}};
        stim_rows[13] = '{ROW_QUERY, 8'd0,   8'h3F, 8'h3F, 8'h3F, 9'd0, 1'b1,
                          '{8'd0, 6'd0, 8'd0, 1'b0}};
        stim_rows[14] = '{ROW_SIZE,  8'd0,   8'h00, 8'h00, 8'h00, 9'd7, 1'b0,
                          '{8'd0, 6'd0, 8'd0, 1'b0}};
        stim_rows[15] = '{ROW_QUERY, 8'd0,   8'hC0, 8'h40, 8'h80, 9'd0, 1'b1,
                          '{8'd1, 6'd0, 8'd0, 1'b0}};
        stim_rows[16] = '{ROW_QUERY, 8'd0,   8'h20, 8'h20, 8'h20, 9'd0, 1'b1,
                          '{8'd2, 6'd0, 8'd0, 1'b0}};
        stim_rows[17] = '{ROW_QUERY, 8'd0,   8'h20, 8'h20, 8'h21, 9'd0, 1'b0,
                          '{8'd0, 6'd0, 8'd0, 1'b0}};
        stim_rows[18] = '{ROW_QUERY, 8'd0,   8'h21, 8'h20, 8'h20, 9'd0, 1'b0,
                          '{8'd0, 6'd0, 8'd0, 1'b0}};
        stim_rows[19] = '{ROW_QUERY, 8'd0,   8'h22, 8'h21, 8'h20, 9'd0, 1'b0,
                          '{8'd0, 6'd0, 8'd0, 1'b0}};
        stim_rows[20] = '{ROW_QUERY, 8'd0,   8'h3F, 8'h00, 8'h3F, 9'd0, 1'b0,
                          '{8'd0, 6'd0, 8'd0, 1'b0}};
        stim_rows[21] = '{ROW_SIZE,  8'd0,   8'h00, 8'h00, 8'h00, 9'd0, 1'b0,
                          '{8'd0, 6'd0, 8'd0, 1'b0}};
        stim_rows[22] = '{ROW_QUERY, 8'd0,   8'hAA, 8'h55, 8'h33, 9'd0, 1'b1,
                          '{8'd0, 6'd0, 8'd0, 1'b1}};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[k]) begin
            if (stim_rows[k].kind == ROW_SIZE)
                set_size(stim_rows[k].size);
            else
                issue((stim_rows[k].kind == ROW_QUERY) ? CMD_QUERY : CMD_WRITE,
                      stim_rows[k].idx, stim_rows[k].red, stim_rows[k].green,
                      stim_rows[k].blue, stim_rows[k].typed, stim_rows[k].result);
        end

        phase      = 0;
        burst_left = 0;
        while (requests_sent < TOTAL_REQUESTS) begin
            case (phase)
                2: size_pick = SIZE_W'(INDEX_LIMIT);
                4: size_pick = '1;
                6: size_pick = '0;
                default: begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)      size_pick = '0;
                    else if (pick == 1) size_pick = 9'd1;
                    else if (pick < 6)  size_pick = SIZE_W'($urandom_range(2, 16));
                    else if (pick < 8)  size_pick = SIZE_W'($urandom_range(17, 255));
                    else if (pick == 8) size_pick = SIZE_W'(INDEX_LIMIT);
                    else                size_pick = SIZE_W'($urandom_range(257, 511));
                end
            endcase
            set_size(size_pick);
            scan = scan_length();

            // fill every entry the search can reach
            for (int i = 0; i < scan; i++)
                if (!written[IDX_W'(i)])
                    issue(CMD_WRITE, IDX_W'(i), random_channel(), random_channel(),
                          random_channel(), 1'b0, '0);

            phase_len = (scan > 32) ? $urandom_range(4, 16) : $urandom_range(20, 60);
            repeat (phase_len) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 20));
                end
                burst_left--;
                if ($urandom_range(0, 3) == 0) begin
                    issue(CMD_WRITE, IDX_W'($urandom_range(0, 255)), random_channel(),
                          random_channel(), random_channel(), 1'b0, '0);
                end else begin
                    pick = $urandom_range(0, 9);
                    if (scan == 0 || pick < 3) begin
                        r = random_channel();
                        g = random_channel();
                        b = random_channel();
                    end else begin
                        base = palette_mem[IDX_W'($urandom_range(0, scan - 1))];
                        if (pick < 7) begin
                            r = {2'($urandom_range(0, 3)), base[2*CHAN_W +: CHAN_W]};
                            g = {2'($urandom_range(0, 3)), base[CHAN_W +: CHAN_W]};
                            b = {2'($urandom_range(0, 3)), base[0 +: CHAN_W]};
                        end else begin
                            r = {2'($urandom_range(0, 3)),
                                 6'(base[2*CHAN_W +: CHAN_W] + $urandom_range(0, 4) - 2)};
                            g = {2'($urandom_range(0, 3)),
                                 6'(base[CHAN_W +: CHAN_W] + $urandom_range(0, 4) - 2)};
                            b = {2'($urandom_range(0, 3)),
                                 6'(base[0 +: CHAN_W] + $urandom_range(0, 4) - 2)};
                        end
                    end
                    issue(CMD_QUERY, IDX_W'($urandom_range(0, 255)), r, g, b, 1'b0, '0);
                end
            end
            phase++;
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/npcs_pkg.sv
hdl/npcs_ram.sv
hdl/npcs_datapath.sv
hdl/npcs_ctrl.sv
hdl/nearest_palette_color_search_top.sv
bench/tb_top.sv
